/* rtl/core/rpm_pkg.sv */
// rpm_pkg: shared types, constants and codes for the prim maze generator
// no dependencies; imported by the top level, rpm_ctrl and rpm_datapath

package rpm_pkg;

  localparam int unsigned MAX_SIDE_DEF = 128;

  localparam logic [7:0] CHAR_WALL    = 8'h23;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_START   = 8'h53;
  localparam logic [7:0] CHAR_END     = 8'h45;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NONE    = 8'h00;

  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    DIR_POS_X = 2'd0,
    DIR_NEG_X = 2'd1,
    DIR_POS_Y = 2'd2,
    DIR_NEG_Y = 2'd3
  } dir_e;

  typedef enum logic [4:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_CLR,
    ST_SEED,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_FRD,
    ST_FLAT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_CARVE1,
    ST_CARVE2,
    ST_PUSH_RD,
    ST_PUSH_CHK,
    ST_START_DONE,
    ST_LAST_RD,
    ST_LAST_WR,
    ST_CELL_RD,
    ST_CELL_CHK,
    ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_CLR,
    CMD_SEED,
    CMD_MOD_GO,
    CMD_PICK,
    CMD_FRD,
    CMD_FLAT,
    CMD_NB_RD,
    CMD_NB_CHK,
    CMD_CARVE1,
    CMD_CARVE2,
    CMD_PUSH_RD,
    CMD_PUSH_CHK,
    CMD_START_DONE,
    CMD_LAST_RD,
    CMD_LAST_WR,
    CMD_CELL_RD,
    CMD_CELL_CHK
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
  } dp_ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic dir_last;
    logic mod_busy;
    logic total_zero;
  } dp_status_t;

endpackage

/* rtl/core/random_prim_maze_generator_unit.sv */
// channel   | handshake            | payload
// command   | start_i, busy_o      | action_i, random_word_i, cell_x_i, cell_y_i
// result    | res_valid_o (strobe) | cell_char_o, carved_*_o, link_*_o, frontier_left_o,
//           |                      | done_res_o
// config    | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
// one transaction at a time; busy_o stays high until the result strobe has gone
// read: result strobe after the ST_CELL_RD and ST_CELL_CHK states; no-op and step on an
// empty frontier: strobe in the cycle after accept; step: waits on the bit-serial remainder
// and the sequential neighbour reads of the cell map ram
// start: clearing pass over the cell map, then seed, frontier pushes and ST_START_DONE;
// after reset the same clearing pass runs with busy_o high
// the receiver cannot stall: each result is valid for the single strobe cycle
// top level; depends on rpm_pkg, rpm_ctrl and rpm_datapath

module random_prim_maze_generator_unit import rpm_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] random_word_i,
  input  logic [7:0]  cell_x_i,
  input  logic [6:0]  cell_y_i,
  output logic        res_valid_o,
  output logic [7:0]  cell_char_o,
  output logic [6:0]  carved_x_o,
  output logic [6:0]  carved_y_o,
  output logic [6:0]  link_x_o,
  output logic [6:0]  link_y_o,
  output logic [14:0] frontier_left_o,
  output logic        done_res_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i
);

  dp_ctrl_t   dp_ctrl;
  dp_status_t dp_status;

  rpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .action_i    (action_i),
    .status_i    (dp_status),
    .ctrl_o      (dp_ctrl),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o)
  );

  rpm_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (dp_ctrl),
    .status_o        (dp_status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .random_word_i   (random_word_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_char_o     (cell_char_o),
    .carved_x_o      (carved_x_o),
    .carved_y_o      (carved_y_o),
    .link_x_o        (link_x_o),
    .link_y_o        (link_y_o),
    .frontier_left_o (frontier_left_o),
    .done_res_o      (done_res_o)
  );

endmodule

/* rtl/core/rpm_ram.sv */
// rpm_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module rpm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rpm_mod.sv */
// rpm_mod: bit-serial restoring remainder of a 32-bit word by the frontier count
// no dependencies; dividend bits are shifted in most significant first and only the remainder is kept

module rpm_mod #(
  parameter int unsigned DIVW = 15
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [31:0]     dividend_i,
  input  logic [DIVW-1:0] divisor_i,
  output logic            busy_o,
  output logic [DIVW-1:0] rem_o
);

  localparam int unsigned DW   = 32;
  localparam int unsigned CNTB = $clog2(DW);

  logic            busy_q;
  logic [CNTB-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [DIVW-1:0] rem_q;
  logic [DIVW-1:0] div_q;
  logic [DIVW:0]   trial;
  logic [DIVW:0]   diff;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTB'(DW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTB'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_q <= diff[DIVW-1:0];
      end else begin
        rem_q <= trial[DIVW-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/rpm_datapath.sv */
// rpm_datapath: cell map, frontier store, size registers and result registers
// depends on rpm_pkg, rpm_ram and rpm_mod; driven by commands from rpm_ctrl

module rpm_datapath import rpm_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_ctrl_t   ctrl_i,
  output dp_status_t status_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic [1:0] action_i,
  input  logic [31:0] random_word_i,
  input  logic [7:0] cell_x_i,
  input  logic [6:0] cell_y_i,
  output logic [7:0] cell_char_o,
  output logic [6:0] carved_x_o,
  output logic [6:0] carved_y_o,
  output logic [6:0] link_x_o,
  output logic [6:0] link_y_o,
  output logic [14:0] frontier_left_o,
  output logic       done_res_o
);

  localparam int unsigned CW         = $clog2(MAX_SIDE);
  localparam int unsigned SW         = CW + 1;
  localparam int unsigned MAW        = 2 * CW;
  localparam int unsigned MAP_DEPTH  = 1 << MAW;
  localparam int unsigned CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW         = $clog2(CELL_COUNT);
  localparam int unsigned CNTW       = $clog2(CELL_COUNT + 1);
  localparam int unsigned CMPW       = 10;

  logic [7:0]      gw_q, gh_q;
  logic [SW-1:0]   act_w_q, act_h_q;
  logic [SW-1:0]   clamp_w, clamp_h;
  logic [CNTW-1:0] total_q;
  logic            gen_done_q, force_done_q;
  logic [31:0]     rnd_q;
  logic [7:0]      rx_q;
  logic [6:0]      ry_q;
  logic [AW-1:0]   pick_q;
  logic [CW-1:0]   fx_q, fy_q, px_q, py_q;
  logic            found_q;
  logic [1:0]      dir_q;
  logic [MAW-1:0]  clr_cnt_q;
  logic [7:0]      char_q;
  logic [CW-1:0]   cx_q, cy_q, lx_q, ly_q;

  logic            map_we, map_wdata, map_rdata;
  logic [MAW-1:0]  map_waddr, map_raddr;
  logic            fr_we;
  logic [AW-1:0]   fr_waddr, fr_raddr;
  logic [MAW-1:0]  fr_wdata, fr_rdata;

  logic            mod_busy;
  logic [CNTW-1:0] mod_rem;

  logic            nb_in;
  logic [CW-1:0]   nbx, nby, btx, bty;
  logic [SW-1:0]   sum_x, sum_y;
  logic            push_ok;

  logic [CMPW-1:0] rx_w, ry_w, aw_w, ah_w;
  logic            rd_in;
  logic [7:0]      rd_char;

  // clamp the size registers into the legal range
  always_comb begin
    clamp_w = SW'(gw_q);
    clamp_h = SW'(gh_q);
    if (CMPW'(gw_q) < CMPW'(3)) begin
      clamp_w = SW'(3);
    end else if (CMPW'(gw_q) > CMPW'(MAX_SIDE)) begin
      clamp_w = SW'(MAX_SIDE);
    end
    if (CMPW'(gh_q) < CMPW'(3)) begin
      clamp_h = SW'(3);
    end else if (CMPW'(gh_q) > CMPW'(MAX_SIDE)) begin
      clamp_h = SW'(MAX_SIDE);
    end
  end

  // neighbour two away and the cell between, in direction dir_q
  assign sum_x = {1'b0, fx_q} + SW'(2);
  assign sum_y = {1'b0, fy_q} + SW'(2);

  always_comb begin
    nbx = fx_q;
    nby = fy_q;
    btx = fx_q;
    bty = fy_q;
    nb_in = 1'b0;
    unique case (dir_e'(dir_q))
      DIR_POS_X: begin
        nb_in = sum_x < act_w_q;
        nbx   = sum_x[CW-1:0];
        btx   = fx_q + CW'(1);
      end
      DIR_NEG_X: begin
        nb_in = fx_q >= CW'(2);
        nbx   = fx_q - CW'(2);
        btx   = fx_q - CW'(1);
      end
      DIR_POS_Y: begin
        nb_in = sum_y < act_h_q;
        nby   = sum_y[CW-1:0];
        bty   = fy_q + CW'(1);
      end
      DIR_NEG_Y: begin
        nb_in = fy_q >= CW'(2);
        nby   = fy_q - CW'(2);
        bty   = fy_q - CW'(1);
      end
      default: ;
    endcase
  end

  assign push_ok = nb_in && !map_rdata && (total_q < CNTW'(CELL_COUNT));

  // cell read decode
  assign rx_w  = CMPW'(rx_q);
  assign ry_w  = CMPW'(ry_q);
  assign aw_w  = CMPW'(act_w_q);
  assign ah_w  = CMPW'(act_h_q);
  assign rd_in = (ry_w < ah_w) && (rx_w <= aw_w);

  always_comb begin
    rd_char = CHAR_NONE;
    if (rd_in) begin
      priority if (rx_w == aw_w) begin
        rd_char = CHAR_NEWLINE;
      end else if (gen_done_q && rx_w == aw_w - CMPW'(2) && ry_w == ah_w - CMPW'(2)) begin
        rd_char = CHAR_END;
      end else if (gen_done_q && rx_w == CMPW'(1) && ry_w == CMPW'(1)) begin
        rd_char = CHAR_START;
      end else begin
        rd_char = map_rdata ? CHAR_SPACE : CHAR_WALL;
      end
    end
  end

  // memory port selection
  always_comb begin
    map_we    = 1'b0;
    map_wdata = 1'b0;
    map_waddr = clr_cnt_q;
    map_raddr = {nby, nbx};
    fr_we     = 1'b0;
    fr_waddr  = total_q[AW-1:0];
    fr_wdata  = {nby, nbx};
    fr_raddr  = pick_q;
    unique case (ctrl_i.cmd)
      CMD_CLR: begin
        map_we = 1'b1;
      end
      CMD_SEED: begin
        map_we    = 1'b1;
        map_wdata = 1'b1;
        map_waddr = {CW'(1), CW'(1)};
      end
      CMD_CARVE1: begin
        map_we    = 1'b1;
        map_wdata = 1'b1;
        map_waddr = {fy_q, fx_q};
      end
      CMD_CARVE2: begin
        map_we    = 1'b1;
        map_wdata = 1'b1;
        map_waddr = {py_q, px_q};
      end
      CMD_CELL_RD: begin
        map_raddr = {CW'(ry_q), CW'(rx_q)};
      end
      CMD_PUSH_CHK: begin
        fr_we = push_ok;
      end
      CMD_LAST_RD: begin
        fr_raddr = AW'(total_q - CNTW'(1));
      end
      CMD_LAST_WR: begin
        fr_we    = 1'b1;
        fr_waddr = pick_q;
        fr_wdata = fr_rdata;
      end
      default: ;
    endcase
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q         <= 8'd15;
      gh_q         <= 8'd15;
      act_w_q      <= SW'(15);
      act_h_q      <= SW'(15);
      total_q      <= '0;
      gen_done_q   <= 1'b0;
      force_done_q <= 1'b0;
      clr_cnt_q    <= '0;
      dir_q        <= '0;
      found_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_GRID_WIDTH:  gw_q <= cfg_wdata_i;
          REG_GRID_HEIGHT: gh_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (ctrl_i.cmd)
        CMD_CAPTURE: begin
          clr_cnt_q    <= '0;
          force_done_q <= (action_e'(action_i) == ACT_STEP) && (total_q == '0);
          if (action_e'(action_i) == ACT_START) begin
            act_w_q <= clamp_w;
            act_h_q <= clamp_h;
            total_q <= '0;
          end
        end
        CMD_CLR: begin
          clr_cnt_q <= clr_cnt_q + MAW'(1);
        end
        CMD_SEED, CMD_CARVE2: begin
          dir_q <= '0;
        end
        CMD_FLAT: begin
          dir_q   <= '0;
          found_q <= 1'b0;
        end
        CMD_NB_CHK: begin
          dir_q <= dir_q + 2'd1;
          if (nb_in && map_rdata && !found_q) begin
            found_q <= 1'b1;
          end
        end
        CMD_PUSH_CHK: begin
          dir_q <= dir_q + 2'd1;
          if (push_ok) begin
            total_q <= total_q + CNTW'(1);
          end
        end
        CMD_START_DONE: begin
          gen_done_q <= (total_q == '0);
        end
        CMD_LAST_RD: begin
          total_q <= total_q - CNTW'(1);
        end
        CMD_LAST_WR: begin
          if (total_q == '0) begin
            gen_done_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_CAPTURE: begin
        rnd_q  <= random_word_i;
        rx_q   <= cell_x_i;
        ry_q   <= cell_y_i;
        char_q <= CHAR_NONE;
        cx_q   <= '0;
        cy_q   <= '0;
        lx_q   <= '0;
        ly_q   <= '0;
      end
      CMD_SEED: begin
        fx_q <= CW'(1);
        fy_q <= CW'(1);
        cx_q <= CW'(1);
        cy_q <= CW'(1);
        lx_q <= CW'(1);
        ly_q <= CW'(1);
      end
      CMD_PICK: begin
        pick_q <= AW'(mod_rem);
      end
      CMD_FLAT: begin
        fx_q <= fr_rdata[CW-1:0];
        fy_q <= fr_rdata[MAW-1:CW];
        px_q <= fr_rdata[CW-1:0];
        py_q <= fr_rdata[MAW-1:CW];
      end
      CMD_NB_CHK: begin
        if (nb_in && map_rdata && !found_q) begin
          px_q <= btx;
          py_q <= bty;
        end
      end
      CMD_CARVE2: begin
        cx_q <= fx_q;
        cy_q <= fy_q;
        lx_q <= px_q;
        ly_q <= py_q;
      end
      CMD_CELL_CHK: begin
        char_q <= rd_char;
      end
      default: ;
    endcase
  end

  rpm_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  rpm_ram #(
    .WIDTH (MAW),
    .DEPTH (CELL_COUNT)
  ) u_frontier_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  rpm_mod #(
    .DIVW (CNTW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (ctrl_i.cmd == CMD_MOD_GO),
    .dividend_i (rnd_q),
    .divisor_i  (total_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  assign status_o.clr_last   = (clr_cnt_q == {MAW{1'b1}});
  assign status_o.dir_last   = (dir_q == 2'd3);
  assign status_o.mod_busy   = mod_busy;
  assign status_o.total_zero = (total_q == '0);

  assign cell_char_o     = char_q;
  assign carved_x_o      = 7'(cx_q);
  assign carved_y_o      = 7'(cy_q);
  assign link_x_o        = 7'(lx_q);
  assign link_y_o        = 7'(ly_q);
  assign frontier_left_o = 15'(total_q);
  assign done_res_o      = gen_done_q | force_done_q;

endmodule

/* rtl/core/rpm_ctrl.sv */
// rpm_ctrl: sequencer for start, step and read transactions
// depends on rpm_pkg; issues one datapath command per cycle

module rpm_ctrl import rpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] action_i,
  input  dp_status_t status_i,
  output dp_ctrl_t   ctrl_o,
  output logic       busy_o,
  output logic       res_valid_o
);

  state_e state_q, state_d;
  logic   is_start_q, is_start_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT_CLR;
      is_start_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      is_start_q <= is_start_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    is_start_d  = is_start_q;
    ctrl_o.cmd  = CMD_NONE;
    unique case (state_q)
      ST_INIT_CLR: begin
        ctrl_o.cmd = CMD_CLR;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.cmd = CMD_CAPTURE;
          is_start_d = (action_e'(action_i) == ACT_START);
          unique case (action_e'(action_i))
            ACT_START: state_d = ST_CLR;
            ACT_STEP:  state_d = status_i.total_zero ? ST_OUT : ST_MOD_GO;
            ACT_READ:  state_d = ST_CELL_RD;
            ACT_NOP:   state_d = ST_OUT;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_CLR: begin
        ctrl_o.cmd = CMD_CLR;
        if (status_i.clr_last) state_d = ST_SEED;
      end
      ST_SEED: begin
        ctrl_o.cmd = CMD_SEED;
        state_d    = ST_PUSH_RD;
      end
      ST_MOD_GO: begin
        ctrl_o.cmd = CMD_MOD_GO;
        state_d    = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (!status_i.mod_busy) begin
          ctrl_o.cmd = CMD_PICK;
          state_d    = ST_FRD;
        end
      end
      ST_FRD: begin
        ctrl_o.cmd = CMD_FRD;
        state_d    = ST_FLAT;
      end
      ST_FLAT: begin
        ctrl_o.cmd = CMD_FLAT;
        state_d    = ST_NB_RD;
      end
      ST_NB_RD: begin
        ctrl_o.cmd = CMD_NB_RD;
        state_d    = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        ctrl_o.cmd = CMD_NB_CHK;
        state_d    = status_i.dir_last ? ST_CARVE1 : ST_NB_RD;
      end
      ST_CARVE1: begin
        ctrl_o.cmd = CMD_CARVE1;
        state_d    = ST_CARVE2;
      end
      ST_CARVE2: begin
        ctrl_o.cmd = CMD_CARVE2;
        state_d    = ST_PUSH_RD;
      end
      ST_PUSH_RD: begin
        ctrl_o.cmd = CMD_PUSH_RD;
        state_d    = ST_PUSH_CHK;
      end
      ST_PUSH_CHK: begin
        ctrl_o.cmd = CMD_PUSH_CHK;
        if (!status_i.dir_last) begin
          state_d = ST_PUSH_RD;
        end else begin
          state_d = is_start_q ? ST_START_DONE : ST_LAST_RD;
        end
      end
      ST_START_DONE: begin
        ctrl_o.cmd = CMD_START_DONE;
        state_d    = ST_OUT;
      end
      ST_LAST_RD: begin
        ctrl_o.cmd = CMD_LAST_RD;
        state_d    = ST_LAST_WR;
      end
      ST_LAST_WR: begin
        ctrl_o.cmd = CMD_LAST_WR;
        state_d    = ST_OUT;
      end
      ST_CELL_RD: begin
        ctrl_o.cmd = CMD_CELL_RD;
        state_d    = ST_CELL_CHK;
      end
      ST_CELL_CHK: begin
        ctrl_o.cmd = CMD_CELL_CHK;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);

endmodule

/* dv/random_prim_maze_generator_unit_test.sv */
// testbench for random_prim_maze_generator_unit: directed and random mazes checked
// against a maze predictor kept in step with every accepted transaction
// depends on rpm_pkg and the rtl of random_prim_maze_generator_unit
`timescale 1ns / 100ps

module random_prim_maze_generator_unit_test;
  import rpm_pkg::*;

  localparam int unsigned SIDE    = MAX_SIDE_DEF;
  localparam int unsigned NCELLS  = SIDE * SIDE;
  localparam int unsigned LIMIT   = 20000000;

  typedef struct packed {
    logic [7:0]  ch;
    logic [6:0]  cx;
    logic [6:0]  cy;
    logic [6:0]  lx;
    logic [6:0]  ly;
    logic [14:0] left;
    logic        done;
  } maze_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  action_i;
  logic [31:0] random_word_i;
  logic [7:0]  cell_x_i;
  logic [6:0]  cell_y_i;
  logic        res_valid_o;
  logic [7:0]  cell_char_o;
  logic [6:0]  carved_x_o;
  logic [6:0]  carved_y_o;
  logic [6:0]  link_x_o;
  logic [6:0]  link_y_o;
  logic [14:0] frontier_left_o;
  logic        done_res_o;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [7:0]  cfg_wdata_i;

  random_prim_maze_generator_unit dut (.*);

  // predictor state
  bit          open_map [NCELLS];
  logic [6:0]  fr_x [NCELLS];
  logic [6:0]  fr_y [NCELLS];
  int unsigned fr_total;
  bit          gen_done;
  logic [7:0]  width_reg, height_reg;
  int          cur_w, cur_h;

  maze_res_t   expected_q[$];
  int          fail_count;
  int          item_count;
  int unsigned cycle_count;
  logic        busy_n;
  int          burst_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) busy_n <= busy_o;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    fail_count++;
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  always @(negedge clk_i) begin
    maze_res_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (cell_char_o != e.ch) report("cell_char", cell_char_o, e.ch);
        if (carved_x_o != e.cx) report("carved_x", carved_x_o, e.cx);
        if (carved_y_o != e.cy) report("carved_y", carved_y_o, e.cy);
        if (link_x_o != e.lx) report("link_x", link_x_o, e.lx);
        if (link_y_o != e.ly) report("link_y", link_y_o, e.ly);
        if (frontier_left_o != e.left) report("frontier_left", frontier_left_o, e.left);
        if (done_res_o != e.done) report("done_res", done_res_o, e.done);
      end
    end
  end

  function automatic int clamp_side(input logic [7:0] v);
    if (v < 3) return 3;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && x < cur_w && y >= 0 && y < cur_h;
  endfunction

  function automatic void queue_cell(input int x, input int y);
    if (on_grid(x, y) && !open_map[y*SIDE+x] && fr_total < NCELLS) begin
      fr_x[fr_total] = 7'(x);
      fr_y[fr_total] = 7'(y);
      fr_total++;
    end
  endfunction

  function automatic void add_around(input int x, input int y);
    queue_cell(x + 2, y);
    queue_cell(x - 2, y);
    queue_cell(x, y + 2);
    queue_cell(x, y - 2);
  endfunction

  function automatic maze_res_t predict_maze(input action_e act, input logic [31:0] rnd,
                                             input int rx, input int ry);
    maze_res_t r;
    int pick, fx, fy, px, py, nx, ny;
    int dx[4] = '{2, -2, 0, 0};
    int dy[4] = '{0, 0, 2, -2};
    r = '0;
    case (act)
      ACT_START: begin
        cur_w = clamp_side(width_reg);
        cur_h = clamp_side(height_reg);
        foreach (open_map[i]) open_map[i] = 1'b0;
        fr_total = 0;
        open_map[SIDE+1] = 1'b1;
        add_around(1, 1);
        gen_done = (fr_total == 0);
        r.cx = 7'd1; r.cy = 7'd1; r.lx = 7'd1; r.ly = 7'd1;
        r.done = gen_done;
      end
      ACT_STEP: begin
        if (fr_total == 0) begin
          r.done = 1'b1;
        end else begin
          pick = int'(rnd % fr_total);
          fx = fr_x[pick];
          fy = fr_y[pick];
          px = fx;
          py = fy;
          for (int d = 0; d < 4; d++) begin
            nx = fx + dx[d];
            ny = fy + dy[d];
            if (on_grid(nx, ny) && open_map[ny*SIDE+nx]) begin
              px = (fx + nx) / 2;
              py = (fy + ny) / 2;
              break;
            end
          end
          open_map[fy*SIDE+fx] = 1'b1;
          open_map[py*SIDE+px] = 1'b1;
          add_around(fx, fy);
          fr_total--;
          fr_x[pick] = fr_x[fr_total];
          fr_y[pick] = fr_y[fr_total];
          if (fr_total == 0) gen_done = 1'b1;
          r.cx = 7'(fx); r.cy = 7'(fy); r.lx = 7'(px); r.ly = 7'(py);
          r.done = gen_done;
        end
      end
      default: begin
        if (act == ACT_READ && ry < cur_h && rx <= cur_w) begin
          if (rx == cur_w) r.ch = CHAR_NEWLINE;
          else if (gen_done && rx == cur_w - 2 && ry == cur_h - 2) r.ch = CHAR_END;
          else if (gen_done && rx == 1 && ry == 1) r.ch = CHAR_START;
          else r.ch = open_map[ry*SIDE+rx] ? CHAR_SPACE : CHAR_WALL;
        end
        r.done = gen_done;
      end
    endcase
    r.left = 15'(fr_total);
    return r;
  endfunction

  // one transaction; start stays high into the next call unless a gap is due
  task automatic send_item(input action_e act, input logic [31:0] rnd = 32'd0,
                           input logic [7:0] x = 8'd0, input logic [6:0] y = 7'd0);
    int gap;
    start_i       <= 1'b1;
    action_i      <= act;
    random_word_i <= rnd;
    cell_x_i      <= x;
    cell_y_i      <= y;
    do @(posedge clk_i); while (busy_n);
    expected_q.push_back(predict_maze(act, rnd, x, y));
    item_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0 || busy_n) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [7:0] w, input logic [7:0] h);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_GRID_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    width_reg = w;
    cfg_index_i <= REG_GRID_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    height_reg = h;
    cfg_we_i <= 1'b0;
  endtask

  task automatic read_random();
    logic [7:0] x;
    logic [6:0] y;
    if ($urandom_range(0, 9) == 0) begin
      x = 8'($urandom_range(0, 255));
      y = 7'($urandom_range(0, 127));
    end else begin
      x = 8'($urandom_range(0, cur_w));
      y = 7'($urandom_range(0, cur_h - 1));
    end
    send_item(ACT_READ, $urandom, x, y);
  endtask

  task automatic test_directed();
    // before any start: empty frontier, default 15 x 15
    send_item(ACT_READ, 32'd0, 8'd0, 7'd0);
    send_item(ACT_READ, 32'd0, 8'd15, 7'd3);
    send_item(ACT_READ, 32'd0, 8'd16, 7'd3);
    send_item(ACT_READ, 32'd0, 8'd2, 7'd15);
    send_item(ACT_READ, 32'hFFFF_FFFF, 8'd255, 7'd127);
    send_item(ACT_NOP, 32'hFFFF_FFFF, 8'hFF, 7'h7F);
    send_item(ACT_STEP, 32'hFFFF_FFFF);
    // smallest grid: frontier empty straight after start, end on start cell
    set_size(8'd3, 8'd3);
    send_item(ACT_START, 32'd0);
    send_item(ACT_READ, 32'd0, 8'd1, 7'd1);
    send_item(ACT_READ, 32'd0, 8'd3, 7'd2);
    send_item(ACT_STEP, 32'd5);
    // values below three and above the maximum clamp
    set_size(8'd0, 8'd255);
    send_item(ACT_START, 32'd0);
    send_item(ACT_STEP, 32'hFFFF_FFFF);
    send_item(ACT_READ, 32'd0, 8'd1, 7'd3);
    send_item(ACT_READ, 32'd0, 8'd3, 7'd127);
    set_size(8'd255, 8'd1);
    send_item(ACT_START, 32'd0);
    send_item(ACT_STEP, 32'd0);
    send_item(ACT_STEP, 32'h8000_0001);
    send_item(ACT_READ, 32'd0, 8'd128, 7'd1);
    send_item(ACT_READ, 32'd0, 8'd127, 7'd2);
    // register write is latched only at the next start
    set_size(8'd7, 8'd5);
    send_item(ACT_READ, 32'd0, 8'd128, 7'd0);
    send_item(ACT_STEP, 32'd3);
  endtask

  task automatic test_random_mazes();
    int extra;
    while (item_count < 1150) begin
      if ($urandom_range(0, 9) == 0) begin
        set_size(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)));
      end else begin
        set_size(8'($urandom_range(3, 17)), 8'($urandom_range(3, 17)));
      end
      send_item(ACT_START, $urandom);
      while (fr_total != 0 && item_count < 1150) begin
        case ($urandom_range(0, 19))
          0:       read_random();
          1:       send_item(ACT_NOP, $urandom, 8'($urandom), 7'($urandom));
          default: send_item(ACT_STEP, $urandom);
        endcase
      end
      extra = $urandom_range(0, 2);
      repeat (extra) send_item(ACT_STEP, $urandom);
      repeat ($urandom_range(4, 20)) read_random();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    action_i      = ACT_NOP;
    random_word_i = '0;
    cell_x_i      = '0;
    cell_y_i      = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_GRID_WIDTH;
    cfg_wdata_i   = '0;
    fail_count    = 0;
    item_count    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    fr_total      = 0;
    gen_done      = 1'b0;
    width_reg     = 8'd15;
    height_reg    = 8'd15;
    cur_w         = 15;
    cur_h         = 15;
    foreach (open_map[i]) open_map[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_mazes();

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
